### rtl/core/dsp_pkg.sv
// Shared types and constants of the duration string parser.
package dsp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [62:0] value_ns;
        logic        status;
    } t_out;

    typedef enum logic [2:0] {
        PH_WS          = 3'd0,
        PH_SIGN        = 3'd1,
        PH_DIGITS      = 3'd2,
        PH_SUFFIX1     = 3'd3,
        PH_SUFFIX_DONE = 3'd4,
        PH_ENDED       = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        UNIT_NONE = 2'd0,
        UNIT_S    = 2'd1,
        UNIT_MS   = 2'd2,
        UNIT_US   = 2'd3
    } t_unit;

    typedef struct packed {
        logic [62:0] magnitude;
        t_unit       unit;
        logic        err;
    } t_fin;

    typedef struct packed {
        logic [61:0] prod_lo;
        logic [30:0] prod_hi;
        logic        sat;
        logic        err;
    } t_prod;

    localparam logic [62:0] VAL_MAX = {63{1'b1}};

    localparam logic [29:0] FACTOR_NONE = 30'd1;
    localparam logic [29:0] FACTOR_S    = 30'd1000000000;
    localparam logic [29:0] FACTOR_MS   = 30'd1000000;
    localparam logic [29:0] FACTOR_US   = 30'd1000;

    localparam logic [62:0] LIMIT_NONE = VAL_MAX;
    localparam logic [62:0] LIMIT_S    = 63'(64'h7FFF_FFFF_FFFF_FFFF / 64'd1000000000);
    localparam logic [62:0] LIMIT_MS   = 63'(64'h7FFF_FFFF_FFFF_FFFF / 64'd1000000);
    localparam logic [62:0] LIMIT_US   = 63'(64'h7FFF_FFFF_FFFF_FFFF / 64'd1000);

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;
    localparam logic [7:0] CH_LO_M     = 8'h6D;
    localparam logic [7:0] CH_LO_N     = 8'h6E;
    localparam logic [7:0] CH_LO_S     = 8'h73;
    localparam logic [7:0] CH_LO_U     = 8'h75;

endpackage

### rtl/core/dsp_parse.sv
// Character state machine and the register holding each finished string.
module dsp_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dsp_pkg::t_in  i_in_data,
    output logic          o_fin_valid,
    input  logic          i_fin_ready,
    output dsp_pkg::t_fin o_fin
);

    dsp_pkg::t_phase r_phase, n_phase;
    logic [62:0]     r_mag, n_mag;
    logic            r_minus, n_minus;
    logic            r_digit, n_digit;
    dsp_pkg::t_unit  r_unit, n_unit;
    logic            r_bad, n_bad;

    logic            r_fin_valid;
    dsp_pkg::t_fin   r_fin;
    dsp_pkg::t_fin   fin_next;

    logic            accept;
    logic [7:0]      c;
    logic [7:0]      lc;
    logic [7:0]      dval;
    logic            is_digit;
    logic            is_space;
    logic [66:0]     wide;
    logic [62:0]     mag_add;

    assign o_in_ready = !r_fin_valid || i_fin_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign c        = i_in_data.ch;
    assign lc       = (c >= dsp_pkg::CH_UP_A && c <= dsp_pkg::CH_UP_Z) ?
                      c + dsp_pkg::CH_CASE_OFS : c;
    assign is_digit = (c >= dsp_pkg::CH_ZERO) && (c <= dsp_pkg::CH_NINE);
    assign is_space = (c == dsp_pkg::CH_SPACE) ||
                      ((c >= dsp_pkg::CH_TAB) && (c <= dsp_pkg::CH_CR));
    assign dval     = c - dsp_pkg::CH_ZERO;

    // Ten times the magnitude plus the digit; anything above 63 bits saturates.
    assign wide    = {r_mag, 3'b000} + {2'b00, r_mag, 1'b0} + {63'd0, dval[3:0]};
    assign mag_add = (wide[66:63] != 4'd0) ? dsp_pkg::VAL_MAX : wide[62:0];

    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_minus = r_minus;
        n_digit = r_digit;
        n_unit  = r_unit;
        n_bad   = r_bad;
        if (!r_bad && r_phase != dsp_pkg::PH_ENDED) begin
            if (c == dsp_pkg::CH_NUL) begin
                if (r_phase == dsp_pkg::PH_SUFFIX1) begin
                    n_bad = 1'b1;
                end else begin
                    n_phase = dsp_pkg::PH_ENDED;
                end
            end else begin
                unique case (r_phase)
                    dsp_pkg::PH_WS: begin
                        if (is_space) begin
                            n_phase = r_phase;
                        end else if (c == dsp_pkg::CH_PLUS || c == dsp_pkg::CH_MINUS) begin
                            n_minus = (c == dsp_pkg::CH_MINUS);
                            n_phase = dsp_pkg::PH_SIGN;
                        end else if (is_digit) begin
                            n_mag   = mag_add;
                            n_digit = 1'b1;
                            n_phase = dsp_pkg::PH_DIGITS;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    dsp_pkg::PH_SIGN: begin
                        if (is_digit) begin
                            n_mag   = mag_add;
                            n_digit = 1'b1;
                            n_phase = dsp_pkg::PH_DIGITS;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    dsp_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            n_mag   = mag_add;
                            n_digit = 1'b1;
                        end else if (lc == dsp_pkg::CH_LO_S) begin
                            n_unit  = dsp_pkg::UNIT_S;
                            n_phase = dsp_pkg::PH_SUFFIX_DONE;
                        end else if (lc == dsp_pkg::CH_LO_M) begin
                            n_unit  = dsp_pkg::UNIT_MS;
                            n_phase = dsp_pkg::PH_SUFFIX1;
                        end else if (lc == dsp_pkg::CH_LO_U) begin
                            n_unit  = dsp_pkg::UNIT_US;
                            n_phase = dsp_pkg::PH_SUFFIX1;
                        end else if (lc == dsp_pkg::CH_LO_N) begin
                            n_unit  = dsp_pkg::UNIT_NONE;
                            n_phase = dsp_pkg::PH_SUFFIX1;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    dsp_pkg::PH_SUFFIX1: begin
                        if (lc == dsp_pkg::CH_LO_S) begin
                            n_phase = dsp_pkg::PH_SUFFIX_DONE;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    default: begin
                        n_bad = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        fin_next.magnitude = n_mag;
        fin_next.unit      = n_unit;
        fin_next.err       = n_bad || !n_digit || (n_phase == dsp_pkg::PH_SUFFIX1) ||
                             (n_minus && (n_mag != 63'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dsp_pkg::PH_WS;
            r_mag   <= 63'd0;
            r_minus <= 1'b0;
            r_digit <= 1'b0;
            r_unit  <= dsp_pkg::UNIT_NONE;
            r_bad   <= 1'b0;
        end else if (accept) begin
            if (i_in_data.last) begin
                r_phase <= dsp_pkg::PH_WS;
                r_mag   <= 63'd0;
                r_minus <= 1'b0;
                r_digit <= 1'b0;
                r_unit  <= dsp_pkg::UNIT_NONE;
                r_bad   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_mag   <= n_mag;
                r_minus <= n_minus;
                r_digit <= n_digit;
                r_unit  <= n_unit;
                r_bad   <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_fin_valid <= accept && i_in_data.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.last) begin
            r_fin <= fin_next;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.last |=>
            r_phase == dsp_pkg::PH_WS && r_mag == 63'd0 && !r_bad && !r_digit)
        else $error("parser state not cleared after the final character");

    a_fin_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fin_valid) |-> $past(accept && i_in_data.last))
        else $error("finished string without a final character transfer");

endmodule

### rtl/core/dsp_scale.sv
// Two-stage scaling of the parsed value to nanoseconds, with saturation.
module dsp_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fin_valid,
    output logic          o_fin_ready,
    input  dsp_pkg::t_fin i_fin,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dsp_pkg::t_out o_out_data
);

    logic [29:0]    factor;
    logic [62:0]    limit;
    logic [61:0]    p_lo;
    logic [60:0]    p_hi;
    dsp_pkg::t_prod prod_next;

    logic           r_s1_valid;
    dsp_pkg::t_prod r_s1;
    logic           s1_ready;

    logic [62:0]    sum;
    dsp_pkg::t_out  out_next;
    logic           r_out_valid;
    dsp_pkg::t_out  r_out;

    always_comb begin
        unique case (i_fin.unit)
            dsp_pkg::UNIT_S: begin
                factor = dsp_pkg::FACTOR_S;
                limit  = dsp_pkg::LIMIT_S;
            end
            dsp_pkg::UNIT_MS: begin
                factor = dsp_pkg::FACTOR_MS;
                limit  = dsp_pkg::LIMIT_MS;
            end
            dsp_pkg::UNIT_US: begin
                factor = dsp_pkg::FACTOR_US;
                limit  = dsp_pkg::LIMIT_US;
            end
            default: begin
                factor = dsp_pkg::FACTOR_NONE;
                limit  = dsp_pkg::LIMIT_NONE;
            end
        endcase
    end

    // The magnitude is split into a 32-bit and a 31-bit half for the multiply.
    assign p_lo = i_fin.magnitude[31:0] * factor;
    assign p_hi = i_fin.magnitude[62:32] * factor;

    always_comb begin
        prod_next.prod_lo = p_lo;
        prod_next.prod_hi = p_hi[30:0];
        prod_next.sat     = i_fin.magnitude > limit;
        prod_next.err     = i_fin.err;
    end

    assign s1_ready    = !r_out_valid || i_out_ready;
    assign o_fin_ready = !r_s1_valid || s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_s1_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid && o_fin_ready) begin
            r_s1 <= prod_next;
        end
    end

    assign sum = {r_s1.prod_hi, 32'd0} + {1'b0, r_s1.prod_lo};

    always_comb begin
        if (r_s1.err) begin
            out_next.value_ns = 63'd0;
            out_next.status   = 1'b1;
        end else if (r_s1.sat) begin
            out_next.value_ns = dsp_pkg::VAL_MAX;
            out_next.status   = 1'b0;
        end else begin
            out_next.value_ns = sum;
            out_next.status   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_ready) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_error_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status |-> r_out.value_ns == 63'd0)
        else $error("error result carries a nonzero value");

    a_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s1_ready && !r_s1.err && r_s1.sat |=>
            r_out_valid && r_out.value_ns == dsp_pkg::VAL_MAX)
        else $error("overflowing product not saturated");

endmodule

### rtl/core/duration_string_parser_top.sv
// Top level of the duration string parser. Characters of a duration string
// arrive one per transfer, the final one marked by last; leading whitespace,
// an optional sign, decimal digits and an optional s, ms, us or ns suffix are
// recognised, and one result in nanoseconds, saturated to 2^63-1, follows each
// string, with status set and a zero value for a malformed or negative string.
// The block takes one character every cycle while the result side keeps up;
// the result for a string passes through the result register of the character
// stage, loaded at the edge that transfers its final character, and then the
// two register stages of the constant multiply that scales the value.
module duration_string_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dsp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dsp_pkg::t_out o_out_data
);

    logic          fin_valid;
    logic          fin_ready;
    dsp_pkg::t_fin fin;

    dsp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    dsp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
